[hdl/scc_pkg.sv]
// Shared types, codes and sizes for the strongly connected component labeler.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none
package scc_pkg;

  localparam int MaxNodes     = 4096;
  localparam int MaxNeighbors = 32;
  localparam int NodeW        = 12;   // node index
  localparam int CountW       = 13;   // counts up to MaxNodes
  localparam int SlotW        = 5;
  localparam int KW           = 6;    // neighbor count up to MaxNeighbors
  localparam int AdjAw        = NodeW + SlotW;
  localparam int FrameW       = NodeW + KW;

  // actions
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_RUN   = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;

  // result status
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_RANGE     = 2'd1;
  localparam logic [1:0] ST_NOT_READY = 2'd2;

  // configuration register indexes
  localparam logic CFG_NODES     = 1'b0;
  localparam logic CFG_NEIGHBORS = 1'b1;

  typedef logic [4:0] step_t;

  // sequencer steps
  localparam step_t S_IDLE  = 5'd0;
  localparam step_t S_CLR   = 5'd1;
  localparam step_t S_ROOT  = 5'd2;
  localparam step_t S_ROOT2 = 5'd3;
  localparam step_t S_TOP   = 5'd4;
  localparam step_t S_EDGE1 = 5'd5;
  localparam step_t S_EDGE2 = 5'd6;
  localparam step_t S_FIN   = 5'd7;
  localparam step_t S_POP   = 5'd8;
  localparam step_t S_POP2  = 5'd9;
  localparam step_t S_RET   = 5'd10;
  localparam step_t S_RET2  = 5'd11;
  localparam step_t S_RET3  = 5'd12;
  localparam step_t S_SZ    = 5'd13;
  localparam step_t S_SZ2   = 5'd14;
  localparam step_t S_SZ3   = 5'd15;
  localparam step_t S_CNT   = 5'd16;
  localparam step_t S_CNT2  = 5'd17;
  localparam step_t S_CNT3  = 5'd18;
  localparam step_t S_PFX   = 5'd19;
  localparam step_t S_PFX2  = 5'd20;
  localparam step_t S_RK    = 5'd21;
  localparam step_t S_RK2   = 5'd22;
  localparam step_t S_RK3   = 5'd23;
  localparam step_t S_RK4   = 5'd24;
  localparam step_t S_DONE  = 5'd25;
  localparam step_t S_Q1    = 5'd26;
  localparam step_t S_Q2    = 5'd27;
  localparam step_t S_Q3    = 5'd28;

  typedef struct packed {
    step_t step;
  } cmd_t;

  typedef struct packed {
    logic clr_end;    // sweep reached node count
    logic root_end;   // root scan reached node count
    logic root_seen;  // root already visited
    logic fp_zero;
    logic edge_left;
    logic v_oob;
    logic v_new;
    logic is_head;    // low link equals visit order
    logic pop_more;
    logic fp_gt1;
    logic last_node;
    logic cnt_end;
    logic pfx_end;
    logic first_hit;
    logic query_ok;
  } stat_t;

endpackage
`default_nettype wire

[hdl/scc_ctrl.sv]
// Sequencer for loads, the component search, ranking and queries.
// Depends on scc_pkg; drives scc_datapath through cmd_t, reads stat_t.
`default_nettype none
module scc_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [1:0]     in_action,
  input  wire scc_pkg::stat_t stat,
  output scc_pkg::cmd_t       cmd,
  output logic                busy
);
  import scc_pkg::*;

  step_t step_r, step_nxt;

  // next step
  always_comb begin
    step_nxt = step_r;
    case (step_r)
      S_IDLE: begin
        if (start && in_action == ACT_RUN) step_nxt = S_CLR;
        else if (start && in_action == ACT_QUERY && stat.query_ok) step_nxt = S_Q1;
      end
      S_CLR:   if (stat.clr_end) step_nxt = S_ROOT;
      S_ROOT:  step_nxt = stat.root_end ? S_SZ : S_ROOT2;
      S_ROOT2: step_nxt = stat.root_seen ? S_ROOT : S_TOP;
      S_TOP: begin
        if (stat.fp_zero) step_nxt = S_ROOT;
        else if (stat.edge_left) step_nxt = S_EDGE1;
        else step_nxt = S_FIN;
      end
      S_EDGE1: step_nxt = stat.v_oob ? S_TOP : S_EDGE2;
      S_EDGE2: step_nxt = S_TOP;
      S_FIN:   step_nxt = stat.is_head ? S_POP : S_RET;
      S_POP:   step_nxt = S_POP2;
      S_POP2:  step_nxt = stat.pop_more ? S_POP : S_RET;
      S_RET:   step_nxt = stat.fp_gt1 ? S_RET2 : S_TOP;
      S_RET2:  step_nxt = S_RET3;
      S_RET3:  step_nxt = S_TOP;
      S_SZ:    step_nxt = S_SZ2;
      S_SZ2:   step_nxt = S_SZ3;
      S_SZ3:   step_nxt = stat.last_node ? S_CNT : S_SZ;
      S_CNT:   step_nxt = stat.cnt_end ? S_PFX : S_CNT2;
      S_CNT2:  step_nxt = S_CNT3;
      S_CNT3:  step_nxt = S_CNT;
      S_PFX:   step_nxt = S_PFX2;
      S_PFX2:  step_nxt = stat.pfx_end ? S_RK : S_PFX;
      S_RK:    step_nxt = S_RK2;
      S_RK2:   step_nxt = S_RK3;
      S_RK3: begin
        if (stat.first_hit) step_nxt = S_RK4;
        else step_nxt = stat.last_node ? S_DONE : S_RK;
      end
      S_RK4:   step_nxt = stat.last_node ? S_DONE : S_RK;
      S_DONE:  step_nxt = S_IDLE;
      S_Q1:    step_nxt = S_Q2;
      S_Q2:    step_nxt = S_Q3;
      S_Q3:    step_nxt = S_IDLE;
      default: step_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) step_r <= S_IDLE;
    else step_r <= step_nxt;
  end

  assign cmd.step = step_r;
  assign busy     = (step_r != S_IDLE);

`ifndef SYNTHESIS
  a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    step_r == S_DONE |=> step_r == S_IDLE) else $error("done not followed by idle");
  a_run_starts_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == S_IDLE && start && in_action == ACT_RUN) |=> step_r == S_CLR)
    else $error("run did not start clear sweep");
  a_busy_holds_q: assert property (@(posedge clk) disable iff (!rst_n)
    step_r == S_Q1 |=> step_r == S_Q2) else $error("query sequence broken");
`endif

endmodule
`default_nettype wire

[hdl/scc_datapath.sv]
// Graph memories, search stacks, ranking tables, config and result registers.
// Depends on scc_pkg; sequenced by scc_ctrl.
`default_nettype none
module scc_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire scc_pkg::cmd_t                 cmd,
  output scc_pkg::stat_t                     stat,
  input  wire logic                          start,
  input  wire logic [1:0]                    in_action,
  input  wire logic [scc_pkg::NodeW-1:0]     in_node,
  input  wire logic [scc_pkg::SlotW-1:0]     in_slot,
  input  wire logic [scc_pkg::NodeW-1:0]     in_neighbor,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [scc_pkg::CountW-1:0]    cfg_data,
  output logic                               out_valid,
  output logic [1:0]                         out_status,
  output logic [scc_pkg::CountW-1:0]         out_component_count,
  output logic [scc_pkg::NodeW-1:0]          out_rank,
  output logic [scc_pkg::CountW-1:0]         out_component_size,
  output logic [scc_pkg::NodeW-1:0]          out_first_member
);
  import scc_pkg::*;

  // memories
  logic [NodeW-1:0]  adj_mem   [0:(MaxNodes*MaxNeighbors)-1];
  logic [CountW-1:0] vo_mem    [0:MaxNodes-1];
  logic [CountW-1:0] ll_mem    [0:MaxNodes-1];
  logic              os_mem    [0:MaxNodes-1];
  logic [NodeW-1:0]  ns_mem    [0:MaxNodes-1];
  logic [FrameW-1:0] fr_mem    [0:MaxNodes-1];
  logic [NodeW-1:0]  lab_mem   [0:MaxNodes-1];
  logic [CountW-1:0] size_mem  [0:MaxNodes-1];
  logic [NodeW-1:0]  first_mem [0:MaxNodes-1];
  logic [NodeW-1:0]  rank_mem  [0:MaxNodes-1];
  logic [CountW-1:0] slot_mem  [0:MaxNodes];

  logic [NodeW-1:0]  adj_rd, ns_rd, lab_rd, first_rd, rank_rd;
  logic [CountW-1:0] vo_rd, ll_rd, size_rd, slot_rd;
  logic              os_rd;
  logic [FrameW-1:0] fr_rd;

  logic              adj_we, vo_we, ll_we, os_we, ns_we, fr_we;
  logic              lab_we, size_we, first_we, rank_we, slot_we;
  logic [AdjAw-1:0]  adj_wa, adj_ra;
  logic [NodeW-1:0]  vo_wa, vo_ra, ll_wa, ll_ra, os_wa, os_ra, ns_wa, ns_ra;
  logic [NodeW-1:0]  fr_wa, fr_ra, lab_wa, lab_ra, size_wa, size_ra;
  logic [NodeW-1:0]  first_wa, first_ra, rank_wa, rank_ra;
  logic [CountW-1:0] slot_wa, slot_ra;
  logic [NodeW-1:0]  adj_wd, ns_wd, lab_wd, first_wd, rank_wd;
  logic [CountW-1:0] vo_wd, ll_wd, size_wd, slot_wd;
  logic              os_wd;
  logic [FrameW-1:0] fr_wd;

  // config and control registers
  logic [CountW-1:0] node_count_r, node_count_nxt;
  logic [KW-1:0]     nbr_count_r, nbr_count_nxt;
  logic              valid_r, valid_nxt;
  logic [CountW-1:0] i_r, i_nxt, sp_r, sp_nxt, fp_r, fp_nxt;
  logic [CountW-1:0] vc_r, vc_nxt, cc_r, cc_nxt, acc_r, acc_nxt;
  logic [CountW-1:0] lu_r, lu_nxt, sz_r, sz_nxt;
  logic [NodeW-1:0]  u_r, u_nxt, c_r, c_nxt, qn_r, qn_nxt;
  logic [KW-1:0]     e_r, e_nxt;
  logic              ov_r, ov_nxt;
  logic [1:0]        os_st_r, os_st_nxt;
  logic [CountW-1:0] ocnt_r, ocnt_nxt, osize_r, osize_nxt;
  logic [NodeW-1:0]  orank_r, orank_nxt, ofirst_r, ofirst_nxt;

  logic [CountW-1:0] n_eff;
  logic [KW-1:0]     k_eff;
  logic [CountW-1:0] vc_inc, sp_dec;
  logic              accept, load_bad, push;

  // clamped register values
  always_comb begin
    if (node_count_r == '0) n_eff = CountW'(1);
    else if (node_count_r > CountW'(MaxNodes)) n_eff = CountW'(MaxNodes);
    else n_eff = node_count_r;
    if (nbr_count_r == '0) k_eff = KW'(1);
    else if (nbr_count_r > KW'(MaxNeighbors)) k_eff = KW'(MaxNeighbors);
    else k_eff = nbr_count_r;
  end

  assign accept   = start && (cmd.step == S_IDLE);
  assign load_bad = ({1'b0, in_node} >= n_eff) || ({1'b0, in_slot} >= k_eff)
                    || ({1'b0, in_neighbor} >= n_eff);
  assign vc_inc   = vc_r + CountW'(1);
  assign sp_dec   = sp_r - CountW'(1);
  assign push     = (vo_rd == '0);

  // status to the sequencer
  always_comb begin
    stat.clr_end   = (i_r == n_eff);
    stat.root_end  = (i_r == n_eff);
    stat.root_seen = (vo_rd != '0);
    stat.fp_zero   = (fp_r == '0);
    stat.edge_left = (e_r < k_eff);
    stat.v_oob     = ({1'b0, adj_rd} >= n_eff);
    stat.v_new     = push;
    stat.is_head   = (ll_rd == vo_rd);
    stat.pop_more  = (ns_rd != u_r) && (sp_r != '0);
    stat.fp_gt1    = (fp_r > CountW'(1));
    stat.last_node = (i_r == n_eff - CountW'(1));
    stat.cnt_end   = (i_r == cc_r);
    stat.pfx_end   = (i_r == '0);
    stat.first_hit = (first_rd == i_r[NodeW-1:0]);
    stat.query_ok  = valid_r && ({1'b0, in_node} < n_eff);
  end

  // per-step register updates and memory commands
  always_comb begin
    node_count_nxt = node_count_r;
    nbr_count_nxt  = nbr_count_r;
    valid_nxt = valid_r;
    i_nxt = i_r;  sp_nxt = sp_r;  fp_nxt = fp_r;
    vc_nxt = vc_r; cc_nxt = cc_r; acc_nxt = acc_r;
    lu_nxt = lu_r; sz_nxt = sz_r; u_nxt = u_r; c_nxt = c_r; e_nxt = e_r;
    qn_nxt = qn_r;
    ov_nxt = 1'b0;
    os_st_nxt = os_st_r; ocnt_nxt = ocnt_r; osize_nxt = osize_r;
    orank_nxt = orank_r; ofirst_nxt = ofirst_r;

    adj_we = 1'b0; vo_we = 1'b0; ll_we = 1'b0; os_we = 1'b0; ns_we = 1'b0;
    fr_we = 1'b0; lab_we = 1'b0; size_we = 1'b0; first_we = 1'b0;
    rank_we = 1'b0; slot_we = 1'b0;
    adj_wa = {in_node, in_slot}; adj_wd = in_neighbor;
    adj_ra = {u_r, e_r[SlotW-1:0]};
    vo_wa = i_r[NodeW-1:0]; vo_wd = '0; vo_ra = i_r[NodeW-1:0];
    ll_wa = u_r; ll_wd = '0; ll_ra = u_r;
    os_wa = i_r[NodeW-1:0]; os_wd = 1'b0; os_ra = adj_rd;
    ns_wa = sp_r[NodeW-1:0]; ns_wd = u_r; ns_ra = sp_dec[NodeW-1:0];
    fr_wa = fp_r[NodeW-1:0]; fr_wd = {u_r, e_r};
    fr_ra = fp_r[NodeW-1:0] - NodeW'(2);
    lab_wa = ns_rd; lab_wd = cc_r[NodeW-1:0]; lab_ra = i_r[NodeW-1:0];
    size_wa = i_r[NodeW-1:0]; size_wd = '0; size_ra = i_r[NodeW-1:0];
    first_wa = c_r; first_wd = i_r[NodeW-1:0]; first_ra = lab_rd;
    rank_wa = c_r; rank_wd = slot_rd[NodeW-1:0]; rank_ra = lab_rd;
    slot_wa = i_r; slot_wd = '0; slot_ra = i_r;

    // configuration writes are for the user to make only while idle; the block does not enforce this
    if (cfg_we) begin
      valid_nxt = 1'b0;
      if (cfg_index == CFG_NODES) node_count_nxt = cfg_data;
      else nbr_count_nxt = cfg_data[KW-1:0];
    end

    case (cmd.step)
      S_IDLE: begin
        if (accept) begin
          ov_nxt = 1'b1;
          ocnt_nxt = valid_nxt ? cc_r : '0;
          orank_nxt = '0; osize_nxt = '0; ofirst_nxt = '0;
          qn_nxt = in_node;
          i_nxt = '0;
          case (in_action)
            ACT_LOAD: begin
              os_st_nxt = load_bad ? ST_RANGE : ST_OK;
              adj_we = !load_bad;
            end
            ACT_RUN: ov_nxt = 1'b0;
            ACT_QUERY: begin
              if (!valid_r) os_st_nxt = ST_NOT_READY;
              else if (!stat.query_ok) os_st_nxt = ST_RANGE;
              else ov_nxt = 1'b0;
            end
            default: os_st_nxt = ST_RANGE;
          endcase
        end
      end
      // clear sweep over visit marks, sizes and the size histogram
      S_CLR: begin
        vo_we = (i_r < n_eff); os_we = (i_r < n_eff); size_we = (i_r < n_eff);
        slot_we = 1'b1;
        if (stat.clr_end) begin
          i_nxt = '0; vc_nxt = '0; cc_nxt = '0; sp_nxt = '0; fp_nxt = '0;
        end else begin
          i_nxt = i_r + CountW'(1);
        end
      end
      S_ROOT: begin
        if (stat.root_end) i_nxt = '0;
      end
      S_ROOT2: begin
        if (stat.root_seen) begin
          i_nxt = i_r + CountW'(1);
        end else begin
          vc_nxt = vc_inc;
          vo_we = 1'b1; vo_wd = vc_inc;
          ll_we = 1'b1; ll_wa = i_r[NodeW-1:0]; ll_wd = vc_inc;
          os_we = 1'b1; os_wd = 1'b1;
          ns_we = 1'b1; ns_wd = i_r[NodeW-1:0];
          sp_nxt = sp_r + CountW'(1);
          fp_nxt = fp_r + CountW'(1);
          u_nxt = i_r[NodeW-1:0]; e_nxt = '0;
        end
      end
      S_TOP: begin
        if (stat.fp_zero) i_nxt = i_r + CountW'(1);
        else if (stat.edge_left) e_nxt = e_r + KW'(1);
        else vo_ra = u_r;
      end
      S_EDGE1: begin
        vo_ra = adj_rd;
        c_nxt = adj_rd;
      end
      // new child is pushed, or a back edge lowers the link
      S_EDGE2: begin
        if (push) begin
          vc_nxt = vc_inc;
          vo_we = 1'b1; vo_wa = c_r; vo_wd = vc_inc;
          ll_we = 1'b1; ll_wa = c_r; ll_wd = vc_inc;
          os_we = 1'b1; os_wa = c_r; os_wd = 1'b1;
          ns_we = 1'b1; ns_wd = c_r;
          sp_nxt = sp_r + CountW'(1);
          fr_we = 1'b1; fr_wa = fp_r[NodeW-1:0] - NodeW'(1);
          fp_nxt = fp_r + CountW'(1);
          u_nxt = c_r; e_nxt = '0;
        end else if (os_rd && (vo_rd < ll_rd)) begin
          ll_we = 1'b1; ll_wd = vo_rd;
        end
      end
      S_FIN: lu_nxt = ll_rd;
      S_POP: sp_nxt = sp_dec;
      S_POP2: begin
        lab_we = 1'b1;
        os_we = 1'b1; os_wa = ns_rd; os_wd = 1'b0;
        if (!stat.pop_more) cc_nxt = cc_r + CountW'(1);
      end
      S_RET: fp_nxt = fp_r - CountW'(1);
      S_RET2: begin
        u_nxt = fr_rd[FrameW-1:KW];
        e_nxt = fr_rd[KW-1:0];
        ll_ra = fr_rd[FrameW-1:KW];
      end
      S_RET3: begin
        if (lu_r < ll_rd) begin
          ll_we = 1'b1; ll_wd = lu_r;
        end
      end
      // sizes and lowest members
      S_SZ2: begin
        c_nxt = lab_rd; size_ra = lab_rd;
      end
      S_SZ3: begin
        first_we = (size_rd == '0);
        size_we = 1'b1; size_wa = c_r; size_wd = size_rd + CountW'(1);
        i_nxt = stat.last_node ? '0 : i_r + CountW'(1);
      end
      // histogram of sizes
      S_CNT: begin
        if (stat.cnt_end) begin
          i_nxt = n_eff; acc_nxt = '0;
        end
      end
      S_CNT2: begin
        sz_nxt = size_rd; slot_ra = size_rd;
      end
      S_CNT3: begin
        slot_we = 1'b1; slot_wa = sz_r; slot_wd = slot_rd + CountW'(1);
        i_nxt = i_r + CountW'(1);
      end
      // exclusive prefix from the largest size down
      S_PFX2: begin
        slot_we = 1'b1; slot_wd = acc_r;
        acc_nxt = acc_r + slot_rd;
        i_nxt = stat.pfx_end ? '0 : i_r - CountW'(1);
      end
      S_RK2: begin
        c_nxt = lab_rd; size_ra = lab_rd;
      end
      S_RK3: begin
        sz_nxt = size_rd; slot_ra = size_rd;
        if (!stat.first_hit && !stat.last_node) i_nxt = i_r + CountW'(1);
      end
      S_RK4: begin
        rank_we = 1'b1;
        slot_we = 1'b1; slot_wa = sz_r; slot_wd = slot_rd + CountW'(1);
        if (!stat.last_node) i_nxt = i_r + CountW'(1);
      end
      S_DONE: begin
        valid_nxt = 1'b1;
        ov_nxt = 1'b1; os_st_nxt = ST_OK; ocnt_nxt = cc_r;
      end
      S_Q1: lab_ra = qn_r;
      S_Q2: size_ra = lab_rd;
      S_Q3: begin
        ov_nxt = 1'b1; os_st_nxt = ST_OK; ocnt_nxt = cc_r;
        orank_nxt = rank_rd; osize_nxt = size_rd; ofirst_nxt = first_rd;
      end
      default: ;
    endcase
  end

  // memory ports: one write and one registered read each
  always_ff @(posedge clk) begin
    if (adj_we) adj_mem[adj_wa] <= adj_wd;
    adj_rd <= adj_mem[adj_ra];
  end
  always_ff @(posedge clk) begin
    if (vo_we) vo_mem[vo_wa] <= vo_wd;
    vo_rd <= vo_mem[vo_ra];
  end
  always_ff @(posedge clk) begin
    if (ll_we) ll_mem[ll_wa] <= ll_wd;
    ll_rd <= ll_mem[ll_ra];
  end
  always_ff @(posedge clk) begin
    if (os_we) os_mem[os_wa] <= os_wd;
    os_rd <= os_mem[os_ra];
  end
  always_ff @(posedge clk) begin
    if (ns_we) ns_mem[ns_wa] <= ns_wd;
    ns_rd <= ns_mem[ns_ra];
  end
  always_ff @(posedge clk) begin
    if (fr_we) fr_mem[fr_wa] <= fr_wd;
    fr_rd <= fr_mem[fr_ra];
  end
  always_ff @(posedge clk) begin
    if (lab_we) lab_mem[lab_wa] <= lab_wd;
    lab_rd <= lab_mem[lab_ra];
  end
  always_ff @(posedge clk) begin
    if (size_we) size_mem[size_wa] <= size_wd;
    size_rd <= size_mem[size_ra];
  end
  always_ff @(posedge clk) begin
    if (first_we) first_mem[first_wa] <= first_wd;
    first_rd <= first_mem[first_ra];
  end
  always_ff @(posedge clk) begin
    if (rank_we) rank_mem[rank_wa] <= rank_wd;
    rank_rd <= rank_mem[rank_ra];
  end
  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    slot_rd <= slot_mem[slot_ra];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= CountW'(1);
      nbr_count_r  <= KW'(1);
      valid_r <= 1'b0;
      ov_r    <= 1'b0;
      i_r <= '0; sp_r <= '0; fp_r <= '0; vc_r <= '0; cc_r <= '0;
    end else begin
      node_count_r <= node_count_nxt;
      nbr_count_r  <= nbr_count_nxt;
      valid_r <= valid_nxt;
      ov_r    <= ov_nxt;
      i_r <= i_nxt; sp_r <= sp_nxt; fp_r <= fp_nxt; vc_r <= vc_nxt; cc_r <= cc_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt; lu_r <= lu_nxt; sz_r <= sz_nxt;
    u_r <= u_nxt; c_r <= c_nxt; e_r <= e_nxt; qn_r <= qn_nxt;
    os_st_r <= os_st_nxt; ocnt_r <= ocnt_nxt; osize_r <= osize_nxt;
    orank_r <= orank_nxt; ofirst_r <= ofirst_nxt;
  end

  assign out_valid           = ov_r;
  assign out_status          = os_st_r;
  assign out_component_count = ocnt_r;
  assign out_rank            = orank_r;
  assign out_component_size  = osize_r;
  assign out_first_member    = ofirst_r;

`ifndef SYNTHESIS
  a_idle_no_frames: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step == S_IDLE) |-> (fp_r == '0)) else $error("frames left after search");
  a_not_ready_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && os_st_r == ST_NOT_READY) |-> (ocnt_r == '0))
    else $error("not_ready result carries a count");
  a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(valid_r) |-> $past(cmd.step) == S_DONE) else $error("results valid without run");
  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= CountW'(MaxNodes)) else $error("node stack overflow");
`endif

endmodule
`default_nettype wire

[hdl/scc_labeler_ranked_core.sv]
// Top level of the ranked strongly connected component labeler.
// Depends on scc_pkg, scc_ctrl and scc_datapath.
//
//  channel  | ports                                          | transfer
//  input    | start, busy, in_action/node/slot/neighbor      | start && !busy
//  result   | out_valid, out_status, out_component_count ... | out_valid, one cycle
//  config   | cfg_we, cfg_index, cfg_data                    | cfg_we
//
// Loads and failed queries leave busy low, and the result follows on the next
// cycle. A good query steps through Q1, Q2 and Q3, limited by the chained label
// then table reads. A run clears the node tables, searches from each unvisited
// root edge by edge, then sizes, counts and ranks the components.
// Synchronous active-low reset; the receiver cannot stall results.
`default_nettype none
module scc_labeler_ranked_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    in_action,
  input  wire logic [scc_pkg::NodeW-1:0]     in_node,
  input  wire logic [scc_pkg::SlotW-1:0]     in_slot,
  input  wire logic [scc_pkg::NodeW-1:0]     in_neighbor,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [scc_pkg::CountW-1:0]    cfg_data,
  output logic                               out_valid,
  output logic [1:0]                         out_status,
  output logic [scc_pkg::CountW-1:0]         out_component_count,
  output logic [scc_pkg::NodeW-1:0]          out_rank,
  output logic [scc_pkg::CountW-1:0]         out_component_size,
  output logic [scc_pkg::NodeW-1:0]          out_first_member
);
  import scc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  scc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_action),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  scc_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .start               (start),
    .in_action           (in_action),
    .in_node             (in_node),
    .in_slot             (in_slot),
    .in_neighbor         (in_neighbor),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_component_count (out_component_count),
    .out_rank            (out_rank),
    .out_component_size  (out_component_size),
    .out_first_member    (out_first_member)
  );

endmodule
`default_nettype wire
